// ----- rtl/core/atit_pkg.sv -----
// Shared types and constants of the four-quadrant angle pipeline.
package atit_pkg;

   localparam int COORD_W  = 16;
   localparam int ANGLE_W  = 16;
   // The ratio min/max in Q1.16 runs 0..65536, so it needs one integer bit.
   localparam int QUO_BITS = 17;

   localparam logic [11:0]          COEF_B       = 12'd2847;
   localparam logic [QUO_BITS:0]    ONE_TURN     = 18'h10000;
   localparam logic [13:0]          EIGHTH_TURN  = 14'd8192;
   localparam logic [ANGLE_W-1:0]   QUARTER_TURN = 16'd16384;
   localparam logic [ANGLE_W-1:0]   HALF_TURN    = 16'd32768;

   typedef struct packed {
      logic steep;
      logic neg_x;
      logic neg_y;
      logic origin;
   } flags_type;

   typedef struct packed {
      logic [COORD_W-1:0]  hi;
      logic [QUO_BITS-1:0] rem;
      logic [QUO_BITS-1:0] quo;
      flags_type           flags;
   } cell_data_type;

endpackage

// ----- rtl/core/atit_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit of min/max per beat.
module atit_div_cell
   import atit_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   input  cell_data_type up_data,
   output logic          up_ready,
   output logic          dn_valid,
   output cell_data_type dn_data,
   input  logic          dn_ready
);

   logic          valid_ff;
   logic          valid_in;
   cell_data_type data_ff;
   cell_data_type data_in;
   logic          take_bit;
   logic [QUO_BITS-1:0] diff;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      take_bit = (up_data.rem >= {1'b0, up_data.hi});
      diff     = up_data.rem - (take_bit ? {1'b0, up_data.hi} : '0);
      data_in       = up_data;
      // The remainder stays below the divisor, so doubling it fits.
      data_in.rem   = {diff[QUO_BITS-2:0], 1'b0};
      data_in.quo   = {up_data.quo[QUO_BITS-2:0], take_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- rtl/core/atit_poly.sv -----
// Polynomial on the ratio, octant and quadrant reflection, and the result register.
module atit_poly
   import atit_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   input  cell_data_type       up_data,
   output logic                up_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [ANGLE_W-1:0]  rsp_tdata
);

   logic                a_valid_ff, a_valid_in, a_ready;
   logic [QUO_BITS-1:0] a_z_ff;
   logic [13:0]         a_inner_ff;
   flags_type           a_flags_ff;

   logic                b_valid_ff, b_valid_in, b_ready;
   logic [13:0]         b_base_ff;
   flags_type           b_flags_ff;

   logic                c_valid_ff, c_valid_in, c_ready;
   logic [ANGLE_W-1:0]  c_angle_ff;

   logic [QUO_BITS-1:0] z_compl;
   logic [28:0]         prod_a;
   logic [13:0]         inner;
   logic [30:0]         prod_b;
   logic [ANGLE_W-1:0]  oct_angle;
   logic [ANGLE_W-1:0]  half_angle;
   logic [ANGLE_W-1:0]  full_angle;

   assign c_ready  = !c_valid_ff || rsp_tready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;

   assign a_valid_in = a_ready ? up_valid   : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   always_comb begin
      z_compl = QUO_BITS'(ONE_TURN - {1'b0, up_data.quo});
      prod_a  = 29'(COEF_B) * 29'(z_compl);
      inner   = EIGHTH_TURN + {1'b0, prod_a[28:16]};
      prod_b  = 31'(a_z_ff) * 31'(a_inner_ff);
   end

   always_comb begin
      oct_angle  = b_flags_ff.steep ? (QUARTER_TURN - {2'b00, b_base_ff})
                                    : {2'b00, b_base_ff};
      half_angle = b_flags_ff.neg_x ? (HALF_TURN - oct_angle) : oct_angle;
      full_angle = b_flags_ff.neg_y ? (ANGLE_W'(0) - half_angle) : half_angle;
      if (b_flags_ff.origin) begin
         full_angle = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && up_valid) begin
         a_z_ff     <= up_data.quo;
         a_inner_ff <= inner;
         a_flags_ff <= up_data.flags;
      end
      if (b_ready && a_valid_ff) begin
         // The base angle never exceeds one eighth turn.
         b_base_ff  <= prod_b[29:16];
         b_flags_ff <= a_flags_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_angle_ff <= full_angle;
      end
   end

   assign rsp_tvalid = c_valid_ff;
   assign rsp_tdata  = c_angle_ff;

   // A ratio of exactly one leaves no fractional bits.
   a_ratio_one : assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_flags_ff.origin && a_z_ff[QUO_BITS-1]) |->
      (a_z_ff[QUO_BITS-2:0] == '0))
      else $error("ratio above one turn fraction");

   a_inner_range : assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> ((a_inner_ff >= EIGHTH_TURN) &&
                      (a_inner_ff <= (EIGHTH_TURN + 14'(COEF_B)))))
      else $error("polynomial inner term out of range");

   a_base_range : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_flags_ff.origin) |-> (b_base_ff <= EIGHTH_TURN))
      else $error("base angle beyond one eighth turn");

endmodule

// ----- rtl/core/atan2_angle_in_turns_top.sv -----
// Top level of the four-quadrant arctangent pipeline returning turns.
//
// Channels: req_ carries one coordinate pair per beat, rsp_ returns one
// angle per beat as an unsigned fraction of a full turn (65536 = one turn).
// Both sides use a valid/ready handshake; a beat moves when both are high.
// There is no configuration port and the block keeps no state between items.
//
// From an accepted request to rsp_tvalid an item passes a front register that
// folds the point into the first octant, the chain of division cells (one
// quotient bit of min/max per cell), two multiplier stages for the
// polynomial and one stage for the reflections and the result register.
// Throughput is one item per cycle while the receiver keeps rsp_tready high;
// every stage has its own valid bit and fills bubbles independently, so a new
// request is taken whenever the first stage is empty or moving on.
//
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
// When the receiver holds rsp_tready low the result stays in place, stages
// behind it keep filling, and req_tready falls only when the whole pipe is full.
module atan2_angle_in_turns_top
   import atit_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [2*COORD_W-1:0]   req_tdata,   // coord_y[15:0], coord_x[31:16]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [ANGLE_W-1:0]     rsp_tdata    // angle_turns[15:0]
);

   logic [COORD_W-1:0] coord_y;
   logic [COORD_W-1:0] coord_x;
   logic [COORD_W-1:0] mag_x;
   logic [COORD_W-1:0] mag_y;
   cell_data_type      front_in;

   logic               front_valid_ff;
   logic               front_valid_in;
   cell_data_type      front_ff;

   logic               chain_valid [QUO_BITS+1];
   logic               chain_ready [QUO_BITS+1];
   cell_data_type      chain_data  [QUO_BITS+1];

   assign coord_y = req_tdata[COORD_W-1:0];
   assign coord_x = req_tdata[2*COORD_W-1:COORD_W];

   always_comb begin
      // The most negative code has magnitude 32768, which still fits unsigned.
      mag_x = coord_x[COORD_W-1] ? (~coord_x + COORD_W'(1)) : coord_x;
      mag_y = coord_y[COORD_W-1] ? (~coord_y + COORD_W'(1)) : coord_y;
      front_in.flags.steep  = (mag_y > mag_x);
      front_in.flags.neg_x  = coord_x[COORD_W-1];
      front_in.flags.neg_y  = coord_y[COORD_W-1];
      front_in.flags.origin = (coord_x == '0) && (coord_y == '0);
      front_in.hi  = front_in.flags.steep ? mag_y : mag_x;
      front_in.rem = {1'b0, (front_in.flags.steep ? mag_x : mag_y)};
      front_in.quo = '0;
   end

   assign req_tready     = !front_valid_ff || chain_ready[0];
   assign front_valid_in = req_tready ? req_tvalid : front_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         front_ff <= front_in;
      end
   end

   assign chain_valid[0] = front_valid_ff;
   assign chain_data[0]  = front_ff;

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      atit_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_data  (chain_data[i]),
         .up_ready (chain_ready[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_data  (chain_data[i+1]),
         .dn_ready (chain_ready[i+1])
      );
   end

   atit_poly u_poly (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (chain_valid[QUO_BITS]),
      .up_data    (chain_data[QUO_BITS]),
      .up_ready   (chain_ready[QUO_BITS]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
